// ----- design/eht_pkg.sv -----
// Shared widths, command and status codes, and controller states of the extendible hash table.
package eht_pkg;

  localparam int KEY_W  = 32;
  localparam int LD_W   = 4;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 24;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef enum logic [18:0] {
    S_CLEAR   = 19'd1,
    S_IDLE    = 19'd2,
    S_LK_DIR  = 19'd4,
    S_LK_BKT  = 19'd8,
    S_LK_CHK  = 19'd16,
    S_FREE    = 19'd32,
    S_DBL     = 19'd64,
    S_SPL_B   = 19'd128,
    S_SPL_N   = 19'd256,
    S_SPL_DIR = 19'd512,
    S_BUD_DIR = 19'd1024,
    S_BUD_BKT = 19'd2048,
    S_BUD_CHK = 19'd4096,
    S_MRG_B2  = 19'd8192,
    S_MRG_DIR = 19'd16384,
    S_HALF    = 19'd32768,
    S_FIN_DIR = 19'd65536,
    S_FIN_BKT = 19'd131072,
    S_FIN_OUT = 19'd262144
  } state_t;

endpackage

// ----- design/eht_ram.sv -----
// Simple dual-port synchronous RAM with one write port and one registered read port.
module eht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/extendible_hash_table.sv -----
// Top level of the extendible hash table: controller, directory, bucket and slot memories.
//
// The input channel carries one command per item: in_tuser selects insert or delete and
// in_tdata holds the 32-bit key. The result channel returns one item per command with the
// status, the key's bucket index and depth, the global depth, the split count and the
// merge flag. The directory, the bucket table (in-use flag and local depth) and the bucket
// slot rows are three synchronous RAMs that a controller walks through.
// A lookup reads the directory, then the bucket table and slot row, and then checks the row.
// Every result is formed by a final directory read and bucket-table read before it loads the
// output register, and a new command is accepted only when the controller is back in idle.
// A delete in a deeper bucket adds the buddy lookup, and while the global depth gd is above
// zero the halving check sweeps all 2^gd directory entries. Each split adds a free-bucket
// scan over up to 2^MAX_GLOBAL_DEPTH bucket entries, a doubling copy of the directory when
// needed, 2 bucket writes, a directory rewrite and a new lookup; a merge adds a step that
// clears the buddy and sets the merged depth, and a directory sweep. These sweeps set the rate.
// After reset the block runs a clearing pass over all 2^MAX_GLOBAL_DEPTH entries of all three
// memories, with in_tready low, and then holds one empty bucket of depth zero.
// The result sits in an output register; a new item is accepted while it waits, and the
// controller only stalls before loading the next result until the receiver takes the old one.
module extendible_hash_table #(
  parameter int MAX_GLOBAL_DEPTH = 8,
  parameter int BUCKET_SLOTS     = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [eht_pkg::KEY_W-1:0] in_tdata,   // key
  input  logic                      in_tuser,   // command
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [eht_pkg::OUT_W-1:0] out_tdata   // status, bucket_index, bucket_depth,
                                                // directory_depth, splits_done, merged
);

  import eht_pkg::*;

  localparam int AW       = MAX_GLOBAL_DEPTH;
  localparam int DIR_SIZE = 1 << AW;
  localparam int S        = BUCKET_SLOTS;
  localparam int SW       = KEY_W + 1;
  localparam int RW       = S * SW;
  localparam int CW       = $clog2(S + 1);
  localparam int BW       = LD_W + 1;

  state_t state_r, state_nxt;
  logic              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [LD_W-1:0]   gd_r, gd_nxt;
  logic [AW-1:0]     h_r, h_nxt;
  logic [AW-1:0]     b_r, b_nxt;
  logic [AW-1:0]     b2_r, b2_nxt;
  logic [AW-1:0]     n_r, n_nxt;
  logic [LD_W-1:0]   d_r, d_nxt;
  logic [RW-1:0]     row_b_r, row_b_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [LD_W-1:0]   splits_r, splits_nxt;
  logic              merged_r, merged_nxt;
  logic [AW:0]       swp_r, swp_nxt;
  logic [AW:0]       lim_r, lim_nxt;
  logic              dly_vld_r, dly_vld_nxt;
  logic              dly2_vld_r, dly2_vld_nxt;
  logic [AW-1:0]     dly_idx_r, dly_idx_nxt;
  logic              any_r, any_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic          dir_we, dir_re;
  logic [AW-1:0] dir_waddr, dir_raddr, dir_wdata, dir_rdata;
  logic          bkt_we, bkt_re;
  logic [AW-1:0] bkt_waddr, bkt_raddr;
  logic [BW-1:0] bkt_wdata, bkt_rdata;
  logic          row_we, row_re;
  logic [AW-1:0] row_waddr, row_raddr;
  logic [RW-1:0] row_wdata, row_rdata;

  eht_ram #(.WIDTH(AW), .DEPTH(DIR_SIZE)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .re(dir_re), .raddr(dir_raddr), .rdata(dir_rdata)
  );

  eht_ram #(.WIDTH(BW), .DEPTH(DIR_SIZE)) u_bkt (
    .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
    .re(bkt_re), .raddr(bkt_raddr), .rdata(bkt_rdata)
  );

  eht_ram #(.WIDTH(RW), .DEPTH(DIR_SIZE)) u_row (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(row_re), .raddr(row_raddr), .rdata(row_rdata)
  );

  logic [AW-1:0]   h_lk, half_aw, buddy, hb_sh, idx_sh;
  logic            hb, idx_bit, issue, done;
  logic [LD_W-1:0] rd_depth;
  logic [7:0]      bidx;

  assign h_lk     = key_r[AW-1:0] & ~({AW{1'b1}} << gd_r);
  assign half_aw  = AW'(1) << gd_r;
  assign buddy    = h_r ^ (AW'(1) << (d_r - 1'b1));
  assign hb_sh    = h_r >> d_r;
  assign hb       = hb_sh[0];
  assign idx_sh   = dly_idx_r >> d_r;
  assign idx_bit  = idx_sh[0];
  assign issue    = swp_r < lim_r;
  assign done     = !issue && !dly_vld_r && !dly2_vld_r;
  assign rd_depth = bkt_rdata[LD_W-1:0];
  assign bidx     = key_r[7:0] & ~(8'hFF << rd_depth);

  // Row operations on the bucket just read and on the registered bucket row.
  logic [S-1:0]           rd_v, rb_v, match, ff_oh, moving;
  logic [S-1:0][KEY_W-1:0] rd_k, rb_k;
  logic [S-1:0][CW-1:0]   rankf, rankv;
  logic                   match_any, free_any, fits;
  logic [CW-1:0]          cnt_b, cnt_rd;
  logic [RW-1:0]          row_add, row_del, row_stay, row_move, row_mrg;

  always_comb begin
    logic [KEY_W-1:0] ksh;
    logic             seen;
    logic [CW-1:0]    accf, accv;
    seen = 1'b0;
    accf = '0;
    accv = '0;
    cnt_b = '0;
    cnt_rd = '0;
    for (int s = 0; s < S; s++) begin
      rd_v[s] = row_rdata[s*SW+KEY_W];
      rd_k[s] = row_rdata[s*SW +: KEY_W];
      rb_v[s] = row_b_r[s*SW+KEY_W];
      rb_k[s] = row_b_r[s*SW +: KEY_W];
    end
    for (int s = 0; s < S; s++) begin
      match[s] = rd_v[s] && (rd_k[s] == key_r);
      ff_oh[s] = !rd_v[s] && !seen;
      seen = seen | !rd_v[s];
      ksh = rb_k[s] >> d_r;
      moving[s] = rb_v[s] & (ksh[0] ^ hb);
      rankf[s] = accf;
      rankv[s] = accv;
      if (!rb_v[s]) begin
        accf = accf + 1'b1;
      end else begin
        cnt_b = cnt_b + 1'b1;
      end
      if (rd_v[s]) begin
        accv = accv + 1'b1;
        cnt_rd = cnt_rd + 1'b1;
      end
    end
    match_any = |match;
    free_any = seen;
    fits = ((CW+1)'(cnt_b) + (CW+1)'(cnt_rd)) <= (CW+1)'(S);
    for (int s = 0; s < S; s++) begin
      row_add[s*SW +: SW] = ff_oh[s] ? {1'b1, key_r} : {rd_v[s], rd_k[s]};
      row_del[s*SW +: SW] = {rd_v[s] & ~match[s], rd_k[s]};
      row_stay[s*SW +: SW] = {rb_v[s] & ~moving[s], rb_k[s]};
      row_move[s*SW +: SW] = {moving[s], rb_k[s]};
      row_mrg[s*SW +: SW] = {rb_v[s], rb_k[s]};
      if (!rb_v[s]) begin
        for (int t = 0; t < S; t++) begin
          if (rd_v[t] && (rankv[t] == rankf[s])) begin
            row_mrg[s*SW +: SW] = {1'b1, rd_k[t]};
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    key_nxt = key_r;
    gd_nxt = gd_r;
    h_nxt = h_r;
    b_nxt = b_r;
    b2_nxt = b2_r;
    n_nxt = n_r;
    d_nxt = d_r;
    row_b_nxt = row_b_r;
    status_nxt = status_r;
    splits_nxt = splits_r;
    merged_nxt = merged_r;
    swp_nxt = swp_r;
    lim_nxt = lim_r;
    dly_vld_nxt = 1'b0;
    dly2_vld_nxt = 1'b0;
    dly_idx_nxt = swp_r[AW-1:0];
    any_nxt = any_r;
    clr_nxt = clr_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    dir_we = 1'b0;
    dir_waddr = dly_idx_r;
    dir_wdata = '0;
    dir_re = 1'b0;
    dir_raddr = swp_r[AW-1:0];
    bkt_we = 1'b0;
    bkt_waddr = b_r;
    bkt_wdata = '0;
    bkt_re = 1'b0;
    bkt_raddr = swp_r[AW-1:0];
    row_we = 1'b0;
    row_waddr = b_r;
    row_wdata = '0;
    row_re = 1'b0;
    row_raddr = dir_rdata;

    unique case (state_r)
      S_CLEAR: begin
        dir_we = 1'b1;
        dir_waddr = clr_r;
        bkt_we = 1'b1;
        bkt_waddr = clr_r;
        bkt_wdata = (clr_r == '0) ? {1'b1, {LD_W{1'b0}}} : '0;
        row_we = 1'b1;
        row_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_tuser;
          key_nxt = in_tdata;
          splits_nxt = '0;
          merged_nxt = 1'b0;
          state_nxt = S_LK_DIR;
        end
      end
      S_LK_DIR: begin
        h_nxt = h_lk;
        dir_re = 1'b1;
        dir_raddr = h_lk;
        state_nxt = S_LK_BKT;
      end
      S_LK_BKT: begin
        b_nxt = dir_rdata;
        bkt_re = 1'b1;
        bkt_raddr = dir_rdata;
        row_re = 1'b1;
        row_raddr = dir_rdata;
        state_nxt = S_LK_CHK;
      end
      S_LK_CHK: begin
        d_nxt = rd_depth;
        if (cmd_r == CMD_INSERT) begin
          row_b_nxt = row_rdata;
          if (match_any) begin
            status_nxt = ST_PRESENT;
            state_nxt = S_FIN_DIR;
          end else if (free_any) begin
            row_we = 1'b1;
            row_wdata = row_add;
            status_nxt = ST_INSERTED;
            state_nxt = S_FIN_DIR;
          end else if (rd_depth >= LD_W'(MAX_GLOBAL_DEPTH)) begin
            status_nxt = ST_FULL;
            state_nxt = S_FIN_DIR;
          end else begin
            swp_nxt = '0;
            lim_nxt = (AW+1)'(DIR_SIZE);
            state_nxt = S_FREE;
          end
        end else begin
          row_we = 1'b1;
          row_wdata = row_del;
          row_b_nxt = row_del;
          status_nxt = match_any ? ST_DELETED : ST_NOT_FOUND;
          if (rd_depth != '0) begin
            state_nxt = S_BUD_DIR;
          end else if (gd_r != '0) begin
            swp_nxt = '0;
            lim_nxt = (AW+1)'(1) << gd_r;
            any_nxt = 1'b0;
            state_nxt = S_HALF;
          end else begin
            state_nxt = S_FIN_DIR;
          end
        end
      end
      S_FREE: begin
        bkt_re = issue;
        dly_vld_nxt = issue;
        if (issue) begin
          swp_nxt = swp_r + 1'b1;
        end
        if (dly_vld_r && !bkt_rdata[LD_W]) begin
          n_nxt = dly_idx_r;
          dly_vld_nxt = 1'b0;
          swp_nxt = '0;
          lim_nxt = (AW+1)'(1) << gd_r;
          state_nxt = (d_r >= gd_r) ? S_DBL : S_SPL_B;
        end else if (!issue && !dly_vld_r) begin
          status_nxt = ST_FULL;
          state_nxt = S_FIN_DIR;
        end
      end
      S_DBL: begin
        dir_re = issue;
        dly_vld_nxt = issue;
        if (issue) begin
          swp_nxt = swp_r + 1'b1;
        end
        if (dly_vld_r) begin
          dir_we = 1'b1;
          dir_waddr = dly_idx_r | half_aw;
          dir_wdata = dir_rdata;
        end
        if (done) begin
          gd_nxt = gd_r + 1'b1;
          state_nxt = S_SPL_B;
        end
      end
      S_SPL_B: begin
        bkt_we = 1'b1;
        bkt_wdata = {1'b1, d_r + 1'b1};
        row_we = 1'b1;
        row_wdata = row_stay;
        state_nxt = S_SPL_N;
      end
      S_SPL_N: begin
        bkt_we = 1'b1;
        bkt_waddr = n_r;
        bkt_wdata = {1'b1, d_r + 1'b1};
        row_we = 1'b1;
        row_waddr = n_r;
        row_wdata = row_move;
        swp_nxt = '0;
        lim_nxt = (AW+1)'(1) << gd_r;
        state_nxt = S_SPL_DIR;
      end
      S_SPL_DIR: begin
        dir_re = issue;
        dly_vld_nxt = issue;
        if (issue) begin
          swp_nxt = swp_r + 1'b1;
        end
        if (dly_vld_r && (dir_rdata == b_r) && (idx_bit != hb)) begin
          dir_we = 1'b1;
          dir_wdata = n_r;
        end
        if (done) begin
          splits_nxt = splits_r + 1'b1;
          state_nxt = S_LK_DIR;
        end
      end
      S_BUD_DIR: begin
        dir_re = 1'b1;
        dir_raddr = buddy;
        state_nxt = S_BUD_BKT;
      end
      S_BUD_BKT: begin
        b2_nxt = dir_rdata;
        bkt_re = 1'b1;
        bkt_raddr = dir_rdata;
        row_re = 1'b1;
        state_nxt = S_BUD_CHK;
      end
      S_BUD_CHK: begin
        if ((b2_r != b_r) && (rd_depth == d_r) && fits) begin
          row_we = 1'b1;
          row_wdata = row_mrg;
          bkt_we = 1'b1;
          bkt_waddr = b2_r;
          state_nxt = S_MRG_B2;
        end else if (gd_r != '0) begin
          swp_nxt = '0;
          lim_nxt = (AW+1)'(1) << gd_r;
          any_nxt = 1'b0;
          state_nxt = S_HALF;
        end else begin
          state_nxt = S_FIN_DIR;
        end
      end
      S_MRG_B2: begin
        row_we = 1'b1;
        row_waddr = b2_r;
        bkt_we = 1'b1;
        bkt_wdata = {1'b1, d_r - 1'b1};
        merged_nxt = 1'b1;
        swp_nxt = '0;
        lim_nxt = (AW+1)'(1) << gd_r;
        state_nxt = S_MRG_DIR;
      end
      S_MRG_DIR: begin
        dir_re = issue;
        dly_vld_nxt = issue;
        if (issue) begin
          swp_nxt = swp_r + 1'b1;
        end
        if (dly_vld_r && (dir_rdata == b2_r)) begin
          dir_we = 1'b1;
          dir_wdata = b_r;
        end
        if (done) begin
          swp_nxt = '0;
          lim_nxt = (AW+1)'(1) << gd_r;
          any_nxt = 1'b0;
          state_nxt = (gd_r != '0) ? S_HALF : S_FIN_DIR;
        end
      end
      S_HALF: begin
        dir_re = issue;
        dly_vld_nxt = issue;
        if (issue) begin
          swp_nxt = swp_r + 1'b1;
        end
        bkt_re = dly_vld_r;
        bkt_raddr = dir_rdata;
        dly2_vld_nxt = dly_vld_r;
        if (dly2_vld_r && (rd_depth >= gd_r)) begin
          any_nxt = 1'b1;
        end
        if (done) begin
          if (!any_r) begin
            gd_nxt = gd_r - 1'b1;
          end
          state_nxt = S_FIN_DIR;
        end
      end
      S_FIN_DIR: begin
        dir_re = 1'b1;
        dir_raddr = h_lk;
        state_nxt = S_FIN_BKT;
      end
      S_FIN_BKT: begin
        bkt_re = 1'b1;
        bkt_raddr = dir_rdata;
        state_nxt = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt = {merged_r, splits_r, gd_r, rd_depth, bidx, status_r};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      gd_r <= '0;
      out_tvalid_r <= 1'b0;
      dly_vld_r <= 1'b0;
      dly2_vld_r <= 1'b0;
      swp_r <= '0;
      lim_r <= '0;
      any_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      gd_r <= gd_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      dly_vld_r <= dly_vld_nxt;
      dly2_vld_r <= dly2_vld_nxt;
      swp_r <= swp_nxt;
      lim_r <= lim_nxt;
      any_r <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    h_r <= h_nxt;
    b_r <= b_nxt;
    b2_r <= b2_nxt;
    n_r <= n_nxt;
    d_r <= d_nxt;
    row_b_r <= row_b_nxt;
    status_r <= status_nxt;
    splits_r <= splits_nxt;
    merged_r <= merged_nxt;
    dly_idx_r <= dly_idx_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_gd_range: assert property (@(posedge clk) disable iff (!rst_n)
    gd_r <= LD_W'(MAX_GLOBAL_DEPTH))
    else $error("global depth beyond its maximum");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_FIN_OUT))
    else $error("result loaded outside the final state");

  a_dbl_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DBL) && dir_we |-> (dly_idx_r < half_aw))
    else $error("directory doubling reads beyond the lower half");

  a_merge_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRG_B2) |-> (d_r != '0))
    else $error("merge of a bucket of depth zero");

  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == S_LK_DIR))
    else $error("accepted item did not start a lookup");

endmodule
